// ----- rtl/satd_pkg.sv -----
// ----------------------------------------------------------------------------
// satd_pkg
// shared types and constants for the speed averaging and turret drive block
// ----------------------------------------------------------------------------
package satd_pkg;

  localparam int unsigned SPEED_W    = 20;
  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int          DRIVE_MAX  = 32767;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRACKING_ENABLE = 3'd0,
    REG_DRIVE_SCALE     = 3'd1,
    REG_DEAD_BAND       = 3'd2,
    REG_LOWER_CLAMP     = 3'd3,
    REG_UPPER_CLAMP     = 3'd4,
    REG_APPROACH_GAIN   = 3'd5,
    REG_DECAY_GAIN      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        tracking_enable;
    logic [15:0] drive_scale;
    logic [14:0] dead_band;
    logic [14:0] lower_clamp;
    logic [14:0] upper_clamp;
    logic [15:0] approach_gain;
    logic [15:0] decay_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tracking_enable: 1'b1,
    drive_scale:     16'd4096,
    dead_band:       15'd328,
    lower_clamp:     15'd3277,
    upper_clamp:     15'd32767,
    approach_gain:   16'd32768,
    decay_gain:      16'd6554
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SHAPE,
    ST_GAIN,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul_scale;
    logic shape;
    logic mul_gain;
    logic update;
    logic div_start;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } ctrl_status_t;

endpackage

// ----- rtl/satd_hist.sv -----
// ----------------------------------------------------------------------------
// satd_hist
// sample ring buffer, registered read of the slot about to be overwritten
// ----------------------------------------------------------------------------
module satd_hist #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned SLOT_W = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic        [SLOT_W-1:0]             slot_i,
  input  logic signed [satd_pkg::SPEED_W-1:0]  wr_data_i,
  output logic signed [satd_pkg::SPEED_W-1:0]  old_data_o
);
  import satd_pkg::*;

  logic signed [SPEED_W-1:0] mem_q [DEPTH];
  logic        [DEPTH-1:0]   valid_q;
  logic signed [SPEED_W-1:0] rd_data_q;
  logic                      rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[slot_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[slot_i];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[slot_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[slot_i];
    end
  end

  assign old_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- rtl/satd_div.sv -----
// ----------------------------------------------------------------------------
// satd_div
// floor division of a running sum by the buffer depth through a reciprocal multiply
// ----------------------------------------------------------------------------
module satd_div #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned SUM_W = 23
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [SUM_W-1:0]             sum_i,
  output logic                                busy_o,
  output logic signed [satd_pkg::SPEED_W-1:0] quot_o
);
  import satd_pkg::*;

  // ceil(2^SHIFT / DEPTH) gives the exact quotient for every numerator below 2^SUM_W
  localparam int unsigned SHIFT   = SUM_W + $clog2(DEPTH);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SHIFT + SPEED_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [SUM_W-1:0]   BIAS  = SUM_W'(DEPTH - 1);

  logic [1:0]         cnt_q, cnt_d;
  logic [SUM_W-1:0]   num_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SPEED_W-1:0] quo_q;
  logic               neg_q;

  logic [SUM_W-1:0]   start_num;
  logic [SPEED_W-1:0] quo_mag;

  // floor for negative sums: -ceil(|s| / d) = -((|s| + d - 1) / d)
  assign start_num = sum_i[SUM_W-1] ? (~unsigned'(sum_i) + SUM_W'(1) + BIAS)
                                    : unsigned'(sum_i);

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = 2'd2;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // load, multiply, then put the sign back
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= start_num;
      neg_q <= sum_i[SUM_W-1];
    end
    if (cnt_q == 2'd2) begin
      prod_q <= PROD_W'(num_q) * PROD_W'(RECIP);
    end
    if (cnt_q == 2'd1) begin
      quo_q <= neg_q ? (~quo_mag + SPEED_W'(1)) : quo_mag;
    end
  end

  assign quo_mag = prod_q[SHIFT +: SPEED_W];
  assign busy_o  = (cnt_q != '0);
  assign quot_o  = signed'(quo_q);

endmodule

// ----- rtl/satd_ctrl.sv -----
// ----------------------------------------------------------------------------
// satd_ctrl
// sequencer for one tick: accept, scale, shape, gain, update, deliver
// ----------------------------------------------------------------------------
module satd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  satd_pkg::ctrl_status_t status_i,
  output satd_pkg::ctrl_cmd_t    cmd_o
);
  import satd_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE:  state_d = ST_SHAPE;
      ST_SHAPE:  state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!status_i.div_busy && status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_SCALE: begin
        cmd_o.mul_scale = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      ST_SHAPE:  cmd_o.shape    = 1'b1;
      ST_GAIN:   cmd_o.mul_gain = 1'b1;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_FINISH: cmd_o.out_load = !status_i.div_busy && status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> cmd_o.mul_scale && cmd_o.div_start)
    else $error("accepted transaction did not start the datapath");
  a_div_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.div_busy)
    else $error("divider restarted while busy");
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> status_i.div_busy)
    else $error("divider did not start");
  a_load_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.div_busy)
    else $error("result loaded before averages were ready");
`endif

endmodule

// ----- rtl/satd_datapath.sv -----
// ----------------------------------------------------------------------------
// satd_datapath
// ring buffers, running sums, dividers, shared multiplier and output register
// ----------------------------------------------------------------------------
module satd_datapath #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  satd_pkg::cfg_t                       cfg_i,
  input  satd_pkg::ctrl_cmd_t                  cmd_i,
  output satd_pkg::ctrl_status_t               status_o,
  input  logic signed [satd_pkg::SPEED_W-1:0]  top_speed_i,
  input  logic signed [satd_pkg::SPEED_W-1:0]  bottom_speed_i,
  input  logic signed [satd_pkg::OFFSET_W-1:0] target_offset_i,
  input  logic                                 target_seen_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic signed [satd_pkg::SPEED_W-1:0]  top_average_o,
  output logic signed [satd_pkg::SPEED_W-1:0]  bottom_average_o,
  output logic signed [satd_pkg::DRIVE_W-1:0]  turret_drive_o
);
  import satd_pkg::*;

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned SUM_W  = SPEED_W + $clog2(DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic signed [19:0] SAT_HI = 20'(DRIVE_MAX);
  localparam logic signed [19:0] SAT_LO = -20'(DRIVE_MAX);

  // ring buffers and running sums
  logic [SLOT_W-1:0]         slot_q, slot_d;
  logic signed [SUM_W-1:0]   top_sum_q, bot_sum_q;
  logic signed [SPEED_W-1:0] top_old, bot_old;
  logic signed [SPEED_W-1:0] top_avg, bot_avg;
  logic                      top_busy, bot_busy;

  satd_hist #(.DEPTH(DEPTH), .SLOT_W(SLOT_W)) u_top_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cmd_i.accept),
    .slot_i     (slot_q),
    .wr_data_i  (top_speed_i),
    .old_data_o (top_old)
  );

  satd_hist #(.DEPTH(DEPTH), .SLOT_W(SLOT_W)) u_bot_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cmd_i.accept),
    .slot_i     (slot_q),
    .wr_data_i  (bottom_speed_i),
    .old_data_o (bot_old)
  );

  assign slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      top_sum_q <= '0;
      bot_sum_q <= '0;
    end else if (cmd_i.accept) begin
      slot_q    <= slot_d;
      top_sum_q <= top_sum_q + SUM_W'(top_speed_i) - SUM_W'(top_old);
      bot_sum_q <= bot_sum_q + SUM_W'(bottom_speed_i) - SUM_W'(bot_old);
    end
  end

  satd_div #(.DEPTH(DEPTH), .SUM_W(SUM_W)) u_top_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .sum_i   (top_sum_q),
    .busy_o  (top_busy),
    .quot_o  (top_avg)
  );

  satd_div #(.DEPTH(DEPTH), .SUM_W(SUM_W)) u_bot_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .sum_i   (bot_sum_q),
    .busy_o  (bot_busy),
    .quot_o  (bot_avg)
  );

  // target and drive path
  logic [OFFSET_W-1:0]       off_q;
  logic                      seen_q;
  logic signed [DRIVE_W-1:0] drv_q;
  logic signed [16:0]        diff_q;
  logic signed [33:0]        prod_q;

  logic [OFFSET_W-1:0] off_mag;
  logic [19:0]         shaped_in;
  logic [14:0]         tgt_mag;
  logic signed [16:0]  tgt;
  logic signed [16:0]  diff_d;
  logic signed [16:0]  mul_a, mul_b;
  logic signed [33:0]  prod_d;
  logic [33:0]         p_mag;
  logic [33:0]         p_rnd;
  logic signed [19:0]  step;
  logic signed [19:0]  base;
  logic signed [19:0]  drv_sum;
  logic signed [DRIVE_W-1:0] drv_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      off_q  <= target_offset_i;
      seen_q <= target_seen_i;
    end
  end

  assign off_mag = off_q[OFFSET_W-1] ? (~off_q + OFFSET_W'(1)) : off_q;

  // scaled magnitude in Q1.15, then deadband and clamps in that order
  assign shaped_in = prod_q[31:12];

  always_comb begin
    if (shaped_in < 20'(cfg_i.dead_band)) begin
      tgt_mag = '0;
    end else if (shaped_in < 20'(cfg_i.lower_clamp)) begin
      tgt_mag = cfg_i.lower_clamp;
    end else if (shaped_in > 20'(cfg_i.upper_clamp)) begin
      tgt_mag = cfg_i.upper_clamp;
    end else begin
      tgt_mag = shaped_in[14:0];
    end
  end

  assign tgt    = off_q[OFFSET_W-1] ? -signed'({2'b00, tgt_mag}) : signed'({2'b00, tgt_mag});
  assign diff_d = tgt - 17'(drv_q);

  // one multiplier shared by the scale and gain steps
  always_comb begin
    if (cmd_i.mul_scale) begin
      mul_a = signed'({1'b0, off_mag});
      mul_b = signed'({1'b0, cfg_i.drive_scale});
    end else if (seen_q) begin
      mul_a = diff_q;
      mul_b = signed'({1'b0, cfg_i.approach_gain});
    end else begin
      mul_a = 17'(drv_q);
      mul_b = signed'({1'b0, cfg_i.decay_gain});
    end
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_scale || cmd_i.mul_gain) begin
      prod_q <= prod_d;
    end
    if (cmd_i.shape) begin
      diff_q <= diff_d;
    end
  end

  // divide by 2^16, round half away from zero, then saturate
  assign p_mag = prod_q[33] ? unsigned'(~prod_q + 34'sd1) : unsigned'(prod_q);
  assign p_rnd = p_mag + 34'd32768;
  assign step  = prod_q[33] ? -signed'({2'b00, p_rnd[33:16]}) : signed'({2'b00, p_rnd[33:16]});
  assign base  = seen_q ? 20'(drv_q) : '0;
  assign drv_sum = base + step;

  always_comb begin
    if (drv_sum > SAT_HI) begin
      drv_d = DRIVE_W'(SAT_HI);
    end else if (drv_sum < SAT_LO) begin
      drv_d = DRIVE_W'(SAT_LO);
    end else begin
      drv_d = drv_sum[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_q <= '0;
    end else if (cmd_i.update && cfg_i.tracking_enable) begin
      drv_q <= drv_d;
    end
  end

  // output register
  logic out_valid_q, out_valid_d;

  assign status_o.div_busy = top_busy || bot_busy;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      top_average_o    <= top_avg;
      bottom_average_o <= bot_avg;
      turret_drive_o   <= drv_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/speed_average_and_turret_drive.sv -----
// ----------------------------------------------------------------------------
// speed_average_and_turret_drive: wheel speed boxcar averages and turret drive
// input transaction to result valid: scale, shape, gain, update, load
// flow: one tick in flight at a time; a held result can delay the next one
// reset: async active low, clears buffers, sums, slot, drive and loads register defaults
// ----------------------------------------------------------------------------
module speed_average_and_turret_drive #(
  parameter int unsigned AVERAGE_DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input transactions
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [satd_pkg::SPEED_W-1:0]    top_speed_i,
  input  logic signed [satd_pkg::SPEED_W-1:0]    bottom_speed_i,
  input  logic signed [satd_pkg::OFFSET_W-1:0]   target_offset_i,
  input  logic                                   target_seen_i,
  // result transactions
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [satd_pkg::SPEED_W-1:0]    top_average_o,
  output logic signed [satd_pkg::SPEED_W-1:0]    bottom_average_o,
  output logic signed [satd_pkg::DRIVE_W-1:0]    turret_drive_o,
  // register writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [satd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [satd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import satd_pkg::*;

  cfg_t         cfg_q, cfg_d;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // register file, always ready; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_TRACKING_ENABLE: cfg_d.tracking_enable = cfg_data_i[0];
        REG_DRIVE_SCALE:     cfg_d.drive_scale     = cfg_data_i;
        REG_DEAD_BAND:       cfg_d.dead_band       = cfg_data_i[14:0];
        REG_LOWER_CLAMP:     cfg_d.lower_clamp     = cfg_data_i[14:0];
        REG_UPPER_CLAMP:     cfg_d.upper_clamp     = cfg_data_i[14:0];
        REG_APPROACH_GAIN:   cfg_d.approach_gain   = cfg_data_i;
        REG_DECAY_GAIN:      cfg_d.decay_gain      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sequencer: one transaction in flight at a time
  satd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // buffers, dividers, multiplier and the output register
  satd_datapath #(.DEPTH(AVERAGE_DEPTH)) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .status_o         (status),
    .top_speed_i      (top_speed_i),
    .bottom_speed_i   (bottom_speed_i),
    .target_offset_i  (target_offset_i),
    .target_seen_i    (target_seen_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .top_average_o    (top_average_o),
    .bottom_average_o (bottom_average_o),
    .turret_drive_o   (turret_drive_o)
  );

endmodule
